// ===== design/mlpfs_pkg.sv =====
// Shared types, codes and the sigmoid lookup table of the MLP forward unit.
package mlpfs_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int TBL_IW        = 8;
  localparam int ACT_W         = 13;
  localparam int VAL_W         = 16;
  localparam int ACC_W         = 40;
  localparam int LC_W          = 3;

  // Item modes
  localparam logic [1:0] MODE_LOAD_W   = 2'd0;
  localparam logic [1:0] MODE_LOAD_ACT = 2'd1;
  localparam logic [1:0] MODE_RUN      = 2'd2;

  // Activation banks: input layer, then two ping-pong banks for computed layers
  localparam logic [1:0] BANK_IN = 2'd0;
  localparam logic [1:0] BANK_A  = 2'd1;
  localparam logic [1:0] BANK_B  = 2'd2;

  typedef logic [ACT_W-1:0] sig_tab_t [TABLE_ENTRIES];

  typedef struct packed {
    logic mac_issue;
    logic mac_first;
    logic mac_last;
    logic act_rd;
  } mlpfs_cmd_t;

  typedef struct packed {
    logic busy;
  } mlpfs_stat_t;

  // Unsigned 64-bit quotient and remainder by shift and subtract, packed as {q, r}.
  function automatic logic [127:0] udivmod(logic [63:0] a, logic [63:0] b);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[63:0], a[k]};
      if (r >= {1'b0, b}) begin
        r    = r - {1'b0, b};
        q[k] = 1'b1;
      end
    end
    return {q, r[63:0]};
  endfunction

  // Entry i = round(4096 / (1 + exp(-(16*i/TABLE_ENTRIES - 8)))).
  // exp(|x|) comes from a Q48 Taylor series in exact integer arithmetic.
  function automatic sig_tab_t sig_build();
    sig_tab_t     t;
    logic [63:0]  num, e, term, den, dd, q, part;
    logic [127:0] qr;
    int           d;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      d    = 16 * i - 8 * TABLE_ENTRIES;
      num  = 64'((d < 0) ? -d : d);
      e    = 64'd1 << 48;
      term = 64'd1 << 48;
      for (int n = 1; n < 400 && term != 64'd0; n++) begin
        den  = 64'(TABLE_ENTRIES) * 64'(n);
        qr   = udivmod(term, den);
        part = qr[63:0] * num;
        term = qr[127:64] * num;
        qr   = udivmod(part, den);
        term = term + qr[127:64];
        e    = e + term;
      end
      dd   = e + (64'd1 << 48);
      qr   = udivmod((64'd1 << 61) + dd, dd << 1);
      q    = qr[127:64];
      t[i] = (d >= 0) ? ACT_W'(64'd4096 - q) : ACT_W'(q);
    end
    return t;
  endfunction

  localparam sig_tab_t SIG_TABLE = sig_build();

endpackage

// ===== design/mlpfs_datapath.sv =====
// Datapath: weight and activation memories, MAC pipeline, sigmoid writeback.
module mlpfs_datapath #(
  parameter int MAX_NEURONS = 64,
  parameter int MAX_LAYERS  = 4,
  parameter int NW          = 6,
  parameter int LW          = 2
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mlpfs_pkg::mlpfs_cmd_t        cmd,
  input  logic [LW-1:0]                w_rd_lay,
  input  logic [NW-1:0]                w_rd_src,
  input  logic [NW-1:0]                w_rd_dst,
  input  logic [1:0]                   a_rd_bank,
  input  logic [NW-1:0]                a_rd_idx,
  input  logic [1:0]                   tgt_bank,
  input  logic [NW-1:0]                tgt_idx,
  input  logic                         ld_w_we,
  input  logic                         ld_a_we,
  input  logic [LW-1:0]                ld_lay,
  input  logic [NW-1:0]                ld_src,
  input  logic [NW-1:0]                ld_dst,
  input  logic [mlpfs_pkg::VAL_W-1:0]  ld_value,
  output mlpfs_pkg::mlpfs_stat_t       stat,
  output logic [mlpfs_pkg::ACT_W-1:0]  rd_act
);
  import mlpfs_pkg::*;

  localparam int WDEPTH = (MAX_LAYERS - 1) << (2 * NW);
  localparam int ADEPTH = 3 << NW;
  localparam int WAW    = LW + 2 * NW;
  localparam int AAW    = NW + 2;
  localparam logic signed [ACC_W-1:0] SAT_HI = 40'sd134217727;
  localparam logic signed [ACC_W-1:0] SAT_LO = -40'sd134217728;
  localparam logic signed [ACC_W-1:0] BIAS   = 40'sd134217728;

  logic [VAL_W-1:0] weight_mem_r [WDEPTH];
  logic [VAL_W-1:0] act_mem_r    [ADEPTH];

  logic [WAW-1:0] w_wr_addr, w_rd_addr;
  logic [AAW-1:0] a_wr_addr, a_rd_addr;
  logic [VAL_W-1:0] a_wr_data;
  logic             a_we;

  logic signed [VAL_W-1:0] w_q_r, a_q_r;
  logic                    s1_vld_r, s1_first_r, s1_last_r;
  logic [1:0]              s1_bank_r;
  logic [NW-1:0]           s1_idx_r;
  logic signed [2*VAL_W-1:0] prod_r;
  logic                    s2_vld_r, s2_first_r, s2_last_r;
  logic [1:0]              s2_bank_r;
  logic [NW-1:0]           s2_idx_r;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic                    done_r;
  logic [1:0]              s3_bank_r;
  logic [NW-1:0]           s3_idx_r;
  logic signed [ACC_W-1:0] clamped, biased;
  logic [TBL_IW-1:0]       tbl_idx;

  assign w_wr_addr = {ld_lay, ld_src, ld_dst};
  assign w_rd_addr = {w_rd_lay, w_rd_src, w_rd_dst};
  assign a_rd_addr = {a_rd_bank, a_rd_idx};

  always_comb begin
    clamped = acc_r;
    if (acc_r > SAT_HI) clamped = SAT_HI;
    if (acc_r < SAT_LO) clamped = SAT_LO;
    biased  = clamped + BIAS;
    tbl_idx = biased[27:20];
  end

  always_comb begin
    a_we      = ld_a_we || done_r;
    a_wr_addr = ld_a_we ? {BANK_IN, ld_src} : {s3_bank_r, s3_idx_r};
    a_wr_data = ld_a_we ? ld_value : VAL_W'(SIG_TABLE[tbl_idx]);
  end

  always_ff @(posedge clk) begin
    if (ld_w_we) weight_mem_r[w_wr_addr] <= ld_value;
    if (cmd.mac_issue) w_q_r <= weight_mem_r[w_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (a_we) act_mem_r[a_wr_addr] <= a_wr_data;
    if (cmd.mac_issue || cmd.act_rd) a_q_r <= act_mem_r[a_rd_addr];
  end

  assign acc_nxt = s2_first_r ? ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      s1_vld_r <= cmd.mac_issue;
      s2_vld_r <= s1_vld_r;
      done_r   <= s2_vld_r && s2_last_r;
    end
    s1_first_r <= cmd.mac_first;
    s1_last_r  <= cmd.mac_last;
    s1_bank_r  <= tgt_bank;
    s1_idx_r   <= tgt_idx;
    prod_r     <= a_q_r * w_q_r;
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    s2_bank_r  <= s1_bank_r;
    s2_idx_r   <= s1_idx_r;
    if (s2_vld_r) acc_r <= acc_nxt;
    s3_bank_r  <= s2_bank_r;
    s3_idx_r   <= s2_idx_r;
  end

  assign stat.busy = s1_vld_r || s2_vld_r || done_r;
  assign rd_act    = a_q_r[ACT_W-1:0];

  a_no_wr_clash: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !ld_a_we) else $error("load collides with sigmoid writeback");
  a_one_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mac_issue |-> !cmd.act_rd) else $error("two reads on one port");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (ld_w_we || ld_a_we) |-> !stat.busy) else $error("load during run");

endmodule

// ===== design/mlpfs_ctrl.sv =====
// Controller: sequences layers, neurons and MAC steps, then emits the output layer.
module mlpfs_ctrl #(
  parameter int NW = 6,
  parameter int LW = 2,
  parameter int SW = 7
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          run_start,
  input  logic [mlpfs_pkg::LC_W-1:0]    lc,
  input  logic [SW-1:0]                 sizes [4],
  input  mlpfs_pkg::mlpfs_stat_t        stat,
  output mlpfs_pkg::mlpfs_cmd_t         cmd,
  output logic [LW-1:0]                 w_rd_lay,
  output logic [NW-1:0]                 w_rd_src,
  output logic [NW-1:0]                 w_rd_dst,
  output logic [1:0]                    a_rd_bank,
  output logic [NW-1:0]                 a_rd_idx,
  output logic [1:0]                    tgt_bank,
  output logic [NW-1:0]                 tgt_idx,
  output logic                          in_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [5:0]                    out_neuron_index,
  output logic                          out_last
);
  import mlpfs_pkg::*;

  typedef enum logic [2:0] {ST_IDLE, ST_MAC, ST_DRAIN, ST_EMIT_RD, ST_EMIT_SHOW} state_t;

  state_t          state_r;
  logic [LC_W-1:0] j_r;
  logic [NW-1:0]   t_r, s_r;
  logic [1:0]      src_bank, dst_bank, fin_bank;
  logic [SW-1:0]   size_cur, size_prev, size_out;
  logic            s_end, t_end, o_end;
  logic [LC_W-1:0] lc_m1;

  assign lc_m1     = lc - LC_W'(1);
  assign size_cur  = sizes[j_r[1:0]];
  assign size_prev = sizes[2'(j_r - LC_W'(1))];
  assign size_out  = sizes[lc_m1[1:0]];
  assign s_end     = SW'(s_r) == size_prev - SW'(1);
  assign t_end     = SW'(t_r) == size_cur - SW'(1);
  assign o_end     = SW'(t_r) == size_out - SW'(1);
  assign src_bank  = (j_r == LC_W'(1)) ? BANK_IN : (j_r[0] ? BANK_B : BANK_A);
  assign dst_bank  = j_r[0] ? BANK_A : BANK_B;
  assign fin_bank  = lc_m1[0] ? BANK_A : BANK_B;

  always_comb begin
    cmd.mac_issue = (state_r == ST_MAC);
    cmd.mac_first = (s_r == '0);
    cmd.mac_last  = s_end;
    cmd.act_rd    = (state_r == ST_EMIT_RD);
    w_rd_lay      = LW'(j_r - LC_W'(1));
    w_rd_src      = s_r;
    w_rd_dst      = t_r;
    a_rd_bank     = (state_r == ST_MAC) ? src_bank : fin_bank;
    a_rd_idx      = (state_r == ST_MAC) ? s_r : t_r;
    tgt_bank      = dst_bank;
    tgt_idx       = t_r;
  end

  assign in_ready         = (state_r == ST_IDLE);
  assign out_valid        = (state_r == ST_EMIT_SHOW);
  assign out_neuron_index = 6'(t_r);
  assign out_last         = o_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      j_r     <= LC_W'(1);
      t_r     <= '0;
      s_r     <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (run_start) begin
            j_r     <= LC_W'(1);
            t_r     <= '0;
            s_r     <= '0;
            state_r <= ST_MAC;
          end
        end
        ST_MAC: begin
          if (s_end) begin
            s_r <= '0;
            if (t_end) begin
              t_r     <= '0;
              state_r <= ST_DRAIN;
            end else begin
              t_r <= t_r + NW'(1);
            end
          end else begin
            s_r <= s_r + NW'(1);
          end
        end
        ST_DRAIN: begin
          if (!stat.busy) begin
            if (j_r == lc_m1) begin
              state_r <= ST_EMIT_RD;
            end else begin
              j_r     <= j_r + LC_W'(1);
              state_r <= ST_MAC;
            end
          end
        end
        ST_EMIT_RD: state_r <= ST_EMIT_SHOW;
        ST_EMIT_SHOW: begin
          if (out_ready) begin
            if (o_end) begin
              state_r <= ST_IDLE;
            end else begin
              t_r     <= t_r + NW'(1);
              state_r <= ST_EMIT_RD;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !stat.busy) else $error("ready while MAC pipeline busy");
  a_no_show_busy: assert property (@(posedge clk) disable iff (!rst_n)
    stat.busy |-> !out_valid) else $error("result shown before layer done");
  a_gap_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |=> (state_r == ST_EMIT_RD))
    else $error("next output not read");

endmodule

// ===== design/mlp_forward_sigmoid_unit.sv =====
// Top level of the MLP forward pass unit with sigmoid activations.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one item per beat. Mode load-weight
//   stores a Q4.12 weight for (layer, source, target); mode load-activation
//   stores an input-layer value; mode run computes every layer and then emits
//   the output layer on the out_ channel, one neuron per beat, last on the
//   final neuron. Mode three and out-of-range loads are dropped.
//   A run issues, per computed layer j, size[j]*size[j-1] MACs (one MAC
//   per cycle through the weight memory port), then waits for the MAC
//   pipeline to drain; each output beat is then read and shown, and held
//   while the receiver stalls. in_ready stays low from the run beat until the
//   last output beat is taken; a stalled receiver just holds the block.
//   Config registers (cfg_we/cfg_index/cfg_wdata) are to be written while
//   idle; the block does not enforce it. Reset restores the register
//   defaults and the controller to idle; memory stays undefined until loaded.
module mlp_forward_sigmoid_unit #(
  parameter int MAX_NEURONS = 64,
  parameter int MAX_LAYERS  = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [6:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [1:0]  in_layer_index,
  input  logic [5:0]  in_source_index,
  input  logic [5:0]  in_target_index,
  input  logic signed [15:0] in_load_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_neuron_index,
  output logic [12:0] out_activation,
  output logic        out_last
);
  import mlpfs_pkg::*;

  localparam int NW    = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
  localparam int LW    = (MAX_LAYERS > 2) ? $clog2(MAX_LAYERS - 1) : 1;
  localparam int SW    = $clog2(MAX_NEURONS + 1) + 1;
  localparam int LCMAX = (MAX_LAYERS < 4) ? MAX_LAYERS : 4;

  localparam logic [2:0] REG_LAYER_COUNT = 3'd0;
  localparam logic [2:0] REG_SIZE0       = 3'd1;
  localparam logic [2:0] REG_SIZE1       = 3'd2;
  localparam logic [2:0] REG_SIZE2       = 3'd3;
  localparam logic [2:0] REG_SIZE3       = 3'd4;

  logic [2:0] layer_count_r;
  logic [6:0] size_r [4];

  logic [LC_W-1:0] lc;
  logic [SW-1:0]   sizes [4];
  logic            in_fire, run_start, idx_ok;

  mlpfs_cmd_t  cmd;
  mlpfs_stat_t stat;
  logic [LW-1:0] w_rd_lay;
  logic [NW-1:0] w_rd_src, w_rd_dst, a_rd_idx, tgt_idx;
  logic [1:0]    a_rd_bank, tgt_bank;

  // Config registers: hold until rewritten, drop writes past the list.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layer_count_r <= 3'd2;
      for (int i = 0; i < 4; i++) size_r[i] <= 7'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LAYER_COUNT: layer_count_r <= cfg_wdata[2:0];
        REG_SIZE0:       size_r[0] <= cfg_wdata;
        REG_SIZE1:       size_r[1] <= cfg_wdata;
        REG_SIZE2:       size_r[2] <= cfg_wdata;
        REG_SIZE3:       size_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Saturate layer count and sizes into the supported range.
  always_comb begin
    if (int'(layer_count_r) < 2) lc = LC_W'(2);
    else if (int'(layer_count_r) > LCMAX) lc = LC_W'(LCMAX);
    else lc = layer_count_r;
    for (int i = 0; i < 4; i++) begin
      if (size_r[i] == 7'd0) sizes[i] = SW'(1);
      else if (int'(size_r[i]) > MAX_NEURONS) sizes[i] = SW'(MAX_NEURONS);
      else sizes[i] = SW'(size_r[i]);
    end
  end

  // Decode the accepted beat; out-of-range loads never reach memory.
  assign in_fire   = in_valid && in_ready;
  assign run_start = in_fire && (in_mode == MODE_RUN);
  assign idx_ok    = (int'(in_source_index) < MAX_NEURONS);

  mlpfs_ctrl #(.NW(NW), .LW(LW), .SW(SW)) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .run_start        (run_start),
    .lc               (lc),
    .sizes            (sizes),
    .stat             (stat),
    .cmd              (cmd),
    .w_rd_lay         (w_rd_lay),
    .w_rd_src         (w_rd_src),
    .w_rd_dst         (w_rd_dst),
    .a_rd_bank        (a_rd_bank),
    .a_rd_idx         (a_rd_idx),
    .tgt_bank         (tgt_bank),
    .tgt_idx          (tgt_idx),
    .in_ready         (in_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_neuron_index (out_neuron_index),
    .out_last         (out_last)
  );

  mlpfs_datapath #(
    .MAX_NEURONS (MAX_NEURONS),
    .MAX_LAYERS  (MAX_LAYERS),
    .NW          (NW),
    .LW          (LW)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .w_rd_lay  (w_rd_lay),
    .w_rd_src  (w_rd_src),
    .w_rd_dst  (w_rd_dst),
    .a_rd_bank (a_rd_bank),
    .a_rd_idx  (a_rd_idx),
    .tgt_bank  (tgt_bank),
    .tgt_idx   (tgt_idx),
    .ld_w_we   (in_fire && (in_mode == MODE_LOAD_W) && idx_ok
                && (int'(in_layer_index) < MAX_LAYERS - 1)
                && (int'(in_target_index) < MAX_NEURONS)),
    .ld_a_we   (in_fire && (in_mode == MODE_LOAD_ACT) && idx_ok),
    .ld_lay    (LW'(in_layer_index)),
    .ld_src    (NW'(in_source_index)),
    .ld_dst    (NW'(in_target_index)),
    .ld_value  (in_load_value),
    .stat      (stat),
    .rd_act    (out_activation)
  );

endmodule

// ===== sim/mlpfs_tb_pkg.sv =====
`timescale 1ns / 1ps
// Register indexes shared by the forward unit testbench files.
package mlpfs_tb_pkg;

  localparam logic [2:0] REG_LAYER_COUNT = 3'd0;
  localparam logic [2:0] REG_SIZE_ZERO   = 3'd1;
  localparam logic [2:0] REG_SIZE_ONE    = 3'd2;
  localparam logic [2:0] REG_SIZE_TWO    = 3'd3;
  localparam logic [2:0] REG_SIZE_THREE  = 3'd4;

  localparam int NEURONS = 64;

endpackage

// ===== sim/mlpfs_checker.sv =====
`timescale 1ns / 1ps
// Checker: predicts forward pass results from observed beats and compares them.
module mlpfs_checker
  import mlpfs_pkg::*;
  import mlpfs_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [6:0]  cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [1:0]  in_layer_index,
  input  logic [5:0]  in_source_index,
  input  logic [5:0]  in_target_index,
  input  logic [15:0] in_load_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [5:0]  out_neuron_index,
  input  logic [12:0] out_activation,
  input  logic        out_last,
  output int          err_count,
  output int          pending
);

  typedef struct {
    logic [5:0]  neuron;
    logic [12:0] act;
    logic        last;
  } neuron_res_t;

  neuron_res_t     out_q[$];
  logic [15:0]     weights[3][NEURONS][NEURONS];
  logic [15:0]     acts[2*NEURONS];
  logic [12:0]     sig_lut[TABLE_ENTRIES];
  logic [2:0]      lc_reg;
  logic [6:0]      size_reg[4];

  // Integer sigmoid entry: exp(|x|) as a Q48 series, then round(4096/(1+e^-x)).
  function automatic logic [12:0] sig_entry(int i);
    longint            d;
    longint unsigned   num, e, term, den, dd, q;
    d    = 16 * i - 8 * TABLE_ENTRIES;
    num  = (d < 0) ? -d : d;
    e    = 64'd1 << 48;
    term = e;
    for (longint unsigned n = 1; n < 400; n++) begin
      den  = TABLE_ENTRIES * n;
      term = (term / den) * num + ((term % den) * num) / den;
      if (term == 0) break;
      e += term;
    end
    dd = e + (64'd1 << 48);
    q  = ((64'd1 << 61) + dd) / (2 * dd);
    return (d >= 0) ? 13'(4096 - q) : 13'(q);
  endfunction

  function automatic int fit_size(logic [6:0] s);
    if (s < 1) return 1;
    if (s > NEURONS) return NEURONS;
    return s;
  endfunction

  function automatic void forward_pass();
    int              lc;
    int              sz[4];
    int              pbase;
    logic [15:0]     nxt[NEURONS];
    longint          acc;
    longint          u;
    neuron_res_t     r;
    for (int k = 0; k < 4; k++) sz[k] = fit_size(size_reg[k]);
    lc = lc_reg;
    if (lc < 2) lc = 2;
    if (lc > 4) lc = 4;
    for (int j = 1; j < lc; j++) begin
      pbase = (j == 1) ? 0 : NEURONS;
      for (int t = 0; t < sz[j]; t++) begin
        acc = 0;
        for (int s = 0; s < sz[j-1]; s++)
          acc += longint'($signed(acts[pbase+s])) * longint'($signed(weights[j-1][s][t]));
        // clamp to [-8,8) in Q8.24, then index the table
        if (acc >= (64'sd1 <<< 27)) acc = (64'sd1 <<< 27) - 1;
        if (acc < -(64'sd1 <<< 27)) acc = -(64'sd1 <<< 27);
        u = (acc + (64'sd1 <<< 27)) >>> 20;
        if (u >= TABLE_ENTRIES) u = TABLE_ENTRIES - 1;
        nxt[t] = 16'(sig_lut[u]);
      end
      for (int t = 0; t < sz[j]; t++) acts[NEURONS+t] = nxt[t];
    end
    for (int t = 0; t < sz[lc-1]; t++) begin
      r.neuron = 6'(t);
      r.act    = acts[NEURONS+t][12:0];
      r.last   = (t + 1 == sz[lc-1]);
      out_q    = {out_q, r};
    end
  endfunction

  initial begin
    err_count = 0;
    pending   = 0;
    for (int i = 0; i < TABLE_ENTRIES; i++) sig_lut[i] = sig_entry(i);
  end

  always @(posedge clk) begin
    neuron_res_t exp_r;
    if (!rst_n) begin
      lc_reg = 3'd2;
      for (int k = 0; k < 4; k++) size_reg[k] = 7'd1;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LAYER_COUNT: lc_reg = cfg_wdata[2:0];
          REG_SIZE_ZERO:   size_reg[0] = cfg_wdata;
          REG_SIZE_ONE:    size_reg[1] = cfg_wdata;
          REG_SIZE_TWO:    size_reg[2] = cfg_wdata;
          REG_SIZE_THREE:  size_reg[3] = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        case (in_mode)
          MODE_LOAD_W:
            if (in_layer_index < 3)
              weights[in_layer_index][in_source_index][in_target_index] = in_load_value;
          MODE_LOAD_ACT: acts[in_source_index] = in_load_value;
          MODE_RUN:      forward_pass();
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (out_q.size() == 0) begin
          $error("unexpected output beat: neuron %0d act %0d", out_neuron_index,
                 out_activation);
          err_count++;
        end else begin
          exp_r = out_q.pop_front();
          if (out_neuron_index !== exp_r.neuron) begin
            $error("neuron_index: expected %0d, got %0d", exp_r.neuron, out_neuron_index);
            err_count++;
          end
          if (out_activation !== exp_r.act) begin
            $error("activation: expected %0d, got %0d", exp_r.act, out_activation);
            err_count++;
          end
          if (out_last !== exp_r.last) begin
            $error("last: expected %0d, got %0d", exp_r.last, out_last);
            err_count++;
          end
        end
      end
    end
    pending = out_q.size();
  end

endmodule

// ===== sim/mlp_forward_sigmoid_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench top: clock, reset, stimulus and verdict for the MLP forward unit.
module mlp_forward_sigmoid_unit_tb;
  import mlpfs_pkg::*;
  import mlpfs_tb_pkg::*;

  localparam int QUIET_LIMIT = 200000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [6:0]  cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_mode;
  logic [1:0]  in_layer_index;
  logic [5:0]  in_source_index;
  logic [5:0]  in_target_index;
  logic signed [15:0] in_load_value;
  logic        out_valid;
  logic        out_ready;
  logic [5:0]  out_neuron_index;
  logic [12:0] out_activation;
  logic        out_last;

  int          err_count;
  int          pending;

  // Track which weights and input activations hold data, so runs never read
  // an entry that was never written.
  bit          w_loaded[3][NEURONS][NEURONS];
  bit          a_loaded[NEURONS];
  int          cur_lc;
  int          cur_size[4];
  int          burst_left;

  // Receiver side: alternating stretches of random stalls, plus a long hold-off
  // on request.
  logic        hold_req;
  int          hold_left;
  int unsigned rx_cyc;
  int          quiet;

  mlp_forward_sigmoid_unit uut (.*);

  mlpfs_checker chk (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    rx_cyc++;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = 400;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rx_cyc[6] ? ($urandom_range(0, 3) != 0) : 1'b1;
    end
  end

  // Watchdog: end the run if no beat moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("mlp_forward_sigmoid_unit_tb: done, errors");
        $finish;
      end
    end
  end

  function automatic int fit_size(int s);
    if (s < 1) return 1;
    if (s > NEURONS) return NEURONS;
    return s;
  endfunction

  // Drive one item, hold it until accepted, then maybe drop valid for a gap.
  task automatic send(logic [1:0] mode, logic [1:0] lay, logic [5:0] src,
                      logic [5:0] dst, logic [15:0] val);
    in_valid        <= 1'b1;
    in_mode         <= mode;
    in_layer_index  <= lay;
    in_source_index <= src;
    in_target_index <= dst;
    in_load_value   <= val;
    do @(posedge clk); while (!in_ready);
    if (mode == MODE_LOAD_W && lay < 3) w_loaded[lay][src][dst] = 1'b1;
    if (mode == MODE_LOAD_ACT) a_loaded[src] = 1'b1;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom);
      1:       return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return 16'($signed($urandom_range(0, 2048)) - 1024);
    endcase
  endfunction

  // Wait until every result has come and the block has settled.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_config(int lc, int s0, int s1, int s2, int s3);
    logic [6:0] vals[5];
    vals = '{7'(lc), 7'(s0), 7'(s1), 7'(s2), 7'(s3)};
    for (int k = 0; k < 5; k++) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= 3'(k);
      cfg_wdata <= vals[k];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_lc = (lc & 7) < 2 ? 2 : ((lc & 7) > 4 ? 4 : (lc & 7));
    cur_size = '{fit_size(s0), fit_size(s1), fit_size(s2), fit_size(s3)};
  endtask

  // Load every weight and input the current shape reads that is still empty.
  task automatic fill_missing();
    for (int s = 0; s < cur_size[0]; s++)
      if (!a_loaded[s]) send(MODE_LOAD_ACT, 2'($urandom), 6'(s), 6'($urandom), pick_value());
    for (int j = 1; j < cur_lc; j++)
      for (int s = 0; s < cur_size[j-1]; s++)
        for (int t = 0; t < cur_size[j]; t++)
          if (!w_loaded[j-1][s][t])
            send(MODE_LOAD_W, 2'(j - 1), 6'(s), 6'(t), pick_value());
  endtask

  initial begin
    int j;
    clk             = 1'b0;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    in_valid        = 1'b0;
    in_mode         = '0;
    in_layer_index  = '0;
    in_source_index = '0;
    in_target_index = '0;
    in_load_value   = '0;
    hold_req        = 1'b0;
    hold_left       = 0;
    rx_cyc          = 0;
    quiet           = 0;
    burst_left      = 5;
    cur_lc          = 2;
    cur_size        = '{1, 1, 1, 1};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: one-by-one net, saturate high, saturate low, zero sum.
    send(MODE_LOAD_ACT, 2'd0, 6'd0, 6'd0, 16'h7fff);
    send(MODE_LOAD_W, 2'd0, 6'd0, 6'd0, 16'h7fff);
    send(MODE_RUN, 2'd0, 6'd0, 6'd0, 16'h0);
    send(MODE_LOAD_W, 2'd0, 6'd0, 6'd0, 16'h8000);
    send(MODE_RUN, 2'd3, 6'd63, 6'd63, 16'hffff);
    send(MODE_LOAD_W, 2'd0, 6'd0, 6'd0, 16'h0000);
    send(MODE_RUN, 2'd1, 6'd21, 6'd42, 16'h5555);
    // Mode three and an out-of-range layer: both dropped.
    send(2'd3, 2'd0, 6'd0, 6'd0, 16'h7fff);
    send(MODE_LOAD_W, 2'd3, 6'd0, 6'd0, 16'h7fff);
    send(MODE_LOAD_ACT, 2'd2, 6'd63, 6'd63, 16'hffff);
    send(MODE_LOAD_W, 2'd0, 6'd0, 6'd0, 16'h0100);
    send(MODE_RUN, 2'd0, 6'd0, 6'd0, 16'h0);
    send(MODE_LOAD_ACT, 2'd0, 6'd0, 6'd0, 16'hf000);
    send(MODE_RUN, 2'd0, 6'd0, 6'd0, 16'h0);
    drain();

    // Shapes stay small except one wide output layer with a saturated size.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       set_config(7, 2, 3, 2, 2);
        1:       set_config(0, 0, 0, 0, 0);
        2:       set_config(2, 1, 127, 127, 127);
        3:       set_config(1, 3, 2, 3, 3);
        default: set_config($urandom_range(0, 7), $urandom_range(0, 3),
                            $urandom_range(0, 3), $urandom_range(0, 3),
                            $urandom_range(0, 3));
      endcase
      fill_missing();
      repeat ($urandom_range(2, 3)) begin
        // Refresh a few entries the current shape reads, with some noise.
        repeat ($urandom_range(1, 2)) begin
          if ($urandom_range(0, 3) == 0) begin
            send(2'($urandom), 2'($urandom), 6'($urandom), 6'($urandom), pick_value());
          end else if ($urandom_range(0, 2) == 0) begin
            send(MODE_LOAD_ACT, 2'($urandom), 6'($urandom_range(0, cur_size[0] - 1)),
                 6'($urandom), pick_value());
          end else begin
            j = $urandom_range(1, cur_lc - 1);
            send(MODE_LOAD_W, 2'(j - 1), 6'($urandom_range(0, cur_size[j-1] - 1)),
                 6'($urandom_range(0, cur_size[j] - 1)), pick_value());
          end
        end
        // Hold the receiver off so outputs back up and the input stalls.
        if (ph == 2 || ph == 5) hold_req = 1'b1;
        send(MODE_RUN, 2'($urandom), 6'($urandom), 6'($urandom), 16'($urandom));
      end
      drain();
    end

    drain();
    if (err_count == 0 && pending == 0) begin
      $display("mlp_forward_sigmoid_unit_tb: done, clean");
    end else begin
      $display("mlp_forward_sigmoid_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
